/* hw/rtl/gld_pkg.sv */
// gif lzw decoder package: command/status codes, fsm states, queue entry type
// no dependencies
package gld_pkg;
	localparam int TableEntries = 4096;
	localparam int StackDepth = 4096;
	localparam int TabAw = 12;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_FETCH = 2'd1,
		CMD_START = 2'd2,
		CMD_BAD = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_PIXEL = 3'd0,
		ST_NEED = 3'd1,
		ST_CLEAR = 3'd2,
		ST_END_OK = 3'd3,
		ST_MISMATCH = 3'd4,
		ST_ILLEGAL = 3'd5,
		ST_ACCEPTED = 3'd6,
		ST_REFUSED = 3'd7
	} status_t;

	localparam logic CFG_MIN_CODE_SIZE = 1'b0;
	localparam logic CFG_EXPECTED_PIXELS = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXP_RD,
		S_EXP_WR,
		S_POP_RD,
		S_POP_OUT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} item_t;
endpackage

/* hw/rtl/gld_front.sv */
// front part: accepts items into a two-entry queue
// depends on gld_pkg
module gld_front import gld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_cmd,
	input  logic [7:0] in_byte,
	output logic       in_stall,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_take
);
	item_t mem_q [2];
	logic  wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{cmd: in_cmd, data_byte: in_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_take && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take && q_valid};
		end
	end
endmodule

/* hw/rtl/gld_back.sv */
// back part: lzw code extraction, string table and pixel stack
// depends on gld_pkg
module gld_back import gld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_take,
	input  logic [3:0]  min_code_size,
	input  logic [31:0] expected_pixels,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  pixel,
	output logic        string_last,
	output logic [31:0] pixel_number
);
	logic [11:0] prefix_mem [TableEntries];
	logic [7:0]  first_mem [TableEntries];
	logic [7:0]  suffix_mem [TableEntries];
	logic [7:0]  stack_mem [StackDepth];

	state_t state_q, state_d;
	logic [12:0] stack_count_q;
	logic [18:0] bit_buffer_q;
	logic [4:0]  bit_count_q;
	logic [3:0]  code_width_q;
	logic [12:0] next_free_q;
	logic [12:0] prev_q;
	logic [7:0]  subblock_q;
	logic        ended_q, finished_q;
	logic [31:0] pixels_q;
	logic [3:0]  root_q;
	logic [11:0] walk_q;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  pixel_q;
	logic        last_q;
	logic [11:0] prefix_rd_q;
	logic [7:0]  suffix_rd_q, first_rd_q, stack_rd_q;
	logic        kw_q;
	logic [7:0]  kw_first_q;
	logic        add_pend_q;

	logic [12:0] clr, firstent;
	logic [11:0] code;
	logic [12:0] cw_mask;
	logic        busy;
	logic        cur_prev_none;
	logic [3:0]  root_lat;
	logic        walk_more;
	logic [12:0] nf_m1;

	assign clr = 13'd1 << root_q;
	assign firstent = clr + 13'd2;
	assign cw_mask = (13'd1 << code_width_q) - 13'd1;
	assign code = bit_buffer_q[11:0] & cw_mask[11:0];
	assign cur_prev_none = prev_q[12];
	assign root_lat = (min_code_size < 4'd2) ? 4'd2 :
		(min_code_size > 4'd8) ? 4'd8 : min_code_size;
	assign walk_more = ({1'b0, walk_q} >= firstent) && (stack_count_q < 13'(StackDepth));
	assign nf_m1 = next_free_q - 13'd1;

	assign busy = out_valid_q && out_stall;
	assign q_take = (state_q == S_IDLE) && q_valid && !busy;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign pixel = pixel_q;
	assign string_last = last_q;
	assign pixel_number = pixels_q;

	// table reads are registered
	always_ff @(posedge clk) begin
		prefix_rd_q <= prefix_mem[walk_q];
		suffix_rd_q <= suffix_mem[walk_q];
		first_rd_q <= first_mem[walk_q];
		stack_rd_q <= stack_mem[stack_count_q[11:0] - 12'd1];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    state_d = state_q;
			S_EXP_RD:  state_d = S_EXP_WR;
			S_EXP_WR:  state_d = state_q;
			S_POP_RD:  state_d = S_POP_OUT;
			S_POP_OUT: state_d = S_IDLE;
			S_OUT:     state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	logic [12:0] nf1;
	assign nf1 = next_free_q + 13'd1;

	always_ff @(posedge clk) begin
		if (state_q == S_EXP_WR && stack_count_q < 13'(StackDepth)) begin
			if (walk_more) stack_mem[stack_count_q[11:0]] <= suffix_rd_q;
			else stack_mem[stack_count_q[11:0]] <= walk_q[7:0];
		end
		// suffix of a new entry is the first symbol of the code, known at walk end
		if (state_q == S_EXP_WR && add_pend_q && !walk_more)
			suffix_mem[nf_m1[11:0]] <= walk_q[7:0];
		if (state_q == S_IDLE && q_take && q_item.cmd == CMD_FETCH
			&& stack_count_q == 13'd0 && !finished_q && {8'd0, bit_count_q} >=
			{9'd0, code_width_q} && !cur_prev_none && next_free_q < 13'(TableEntries)) begin
			if ({1'b0, code} < next_free_q && {1'b0, code} != clr && {1'b0, code} != clr + 13'd1) begin
				prefix_mem[next_free_q[11:0]] <= prev_q[11:0];
				first_mem[next_free_q[11:0]] <= (prev_q < clr) ? prev_q[7:0] : kw_first_q;
			end else if ({1'b0, code} == next_free_q) begin
				prefix_mem[next_free_q[11:0]] <= prev_q[11:0];
				first_mem[next_free_q[11:0]] <= (prev_q < clr) ? prev_q[7:0] : kw_first_q;
				suffix_mem[next_free_q[11:0]] <= (prev_q < clr) ? prev_q[7:0] : kw_first_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stack_count_q <= '0;
			bit_buffer_q <= '0;
			bit_count_q <= '0;
			root_q <= 4'd8;
			code_width_q <= 4'd9;
			next_free_q <= 13'd258;
			prev_q <= 13'h1000;
			subblock_q <= '0;
			ended_q <= 1'b0;
			finished_q <= 1'b0;
			pixels_q <= '0;
			walk_q <= '0;
			out_valid_q <= 1'b0;
			status_q <= ST_REFUSED;
			pixel_q <= '0;
			last_q <= 1'b0;
			kw_q <= 1'b0;
			kw_first_q <= '0;
			add_pend_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_take) begin
					pixel_q <= '0;
					last_q <= 1'b0;
					case (q_item.cmd)
						CMD_START: begin
							root_q <= root_lat;
							code_width_q <= root_lat + 4'd1;
							next_free_q <= (13'd1 << root_lat) + 13'd2;
							prev_q <= 13'h1000;
							stack_count_q <= '0;
							bit_buffer_q <= '0;
							bit_count_q <= '0;
							subblock_q <= '0;
							ended_q <= 1'b0;
							finished_q <= 1'b0;
							pixels_q <= '0;
							status_q <= ST_ACCEPTED;
							state_q <= S_OUT;
						end
						CMD_PUSH: begin
							state_q <= S_OUT;
							if (ended_q) status_q <= ST_REFUSED;
							else if (subblock_q == 8'd0) begin
								if (q_item.data_byte == 8'd0) ended_q <= 1'b1;
								else subblock_q <= q_item.data_byte;
								status_q <= ST_ACCEPTED;
							end else if (finished_q) begin
								subblock_q <= subblock_q - 8'd1;
								status_q <= ST_ACCEPTED;
							end else if (bit_count_q > 5'd11) status_q <= ST_REFUSED;
							else begin
								bit_buffer_q <= bit_buffer_q |
									19'({11'd0, q_item.data_byte} << bit_count_q);
								bit_count_q <= bit_count_q + 5'd8;
								subblock_q <= subblock_q - 8'd1;
								status_q <= ST_ACCEPTED;
							end
						end
						CMD_FETCH: begin
							if (stack_count_q != 13'd0) state_q <= S_POP_RD;
							else if (finished_q || {1'b0, bit_count_q} < {2'd0, code_width_q}) begin
								state_q <= S_OUT;
								if (finished_q || ended_q) begin
									finished_q <= 1'b1;
									status_q <= (pixels_q == expected_pixels) ?
										ST_END_OK : ST_MISMATCH;
								end else status_q <= ST_NEED;
							end else begin
								bit_buffer_q <= bit_buffer_q >> code_width_q;
								bit_count_q <= bit_count_q - {1'b0, code_width_q};
								if ({1'b0, code} == clr + 13'd1) begin
									finished_q <= 1'b1;
									status_q <= (pixels_q == expected_pixels) ?
										ST_END_OK : ST_MISMATCH;
									state_q <= S_OUT;
								end else if ({1'b0, code} == clr) begin
									code_width_q <= root_q + 4'd1;
									next_free_q <= firstent;
									prev_q <= 13'h1000;
									status_q <= ST_CLEAR;
									state_q <= S_OUT;
								end else if ({1'b0, code} < next_free_q ||
									({1'b0, code} == next_free_q && !cur_prev_none)) begin
									kw_q <= ({1'b0, code} == next_free_q);
									add_pend_q <= !cur_prev_none &&
										next_free_q < 13'(TableEntries) &&
										({1'b0, code} != next_free_q);
									if (!cur_prev_none && next_free_q < 13'(TableEntries)) begin
										next_free_q <= nf1;
										if ((nf1 & cw_mask) == 13'd0 && nf1 < 13'(TableEntries)
											&& code_width_q < 4'd12)
											code_width_q <= code_width_q + 4'd1;
									end
									prev_q <= {1'b0, code};
									walk_q <= code;
									state_q <= S_EXP_RD;
								end else begin
									status_q <= ST_ILLEGAL;
									state_q <= S_OUT;
								end
							end
						end
						default: begin
							status_q <= ST_REFUSED;
							state_q <= S_OUT;
						end
					endcase
				end
				S_EXP_RD: state_q <= state_d;
				S_EXP_WR: begin
					if (stack_count_q < 13'(StackDepth)) stack_count_q <= stack_count_q + 13'd1;
					if (walk_more) begin
						walk_q <= prefix_rd_q;
						state_q <= S_EXP_RD;
					end else begin
						kw_first_q <= walk_q[7:0];
						add_pend_q <= 1'b0;
						state_q <= S_POP_RD;
					end
				end
				S_POP_RD: state_q <= state_d;
				S_POP_OUT: if (!busy) begin
					stack_count_q <= stack_count_q - 13'd1;
					pixel_q <= stack_rd_q;
					last_q <= (stack_count_q == 13'd1);
					if (pixels_q != 32'hFFFF_FFFF) pixels_q <= pixels_q + 32'd1;
					status_q <= ST_PIXEL;
					out_valid_q <= 1'b1;
					state_q <= state_d;
				end
				S_OUT: if (!busy) begin
					out_valid_q <= 1'b1;
					state_q <= state_d;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
	logic unused_kw;
	assign unused_kw = kw_q ^ (|first_rd_q);
endmodule

/* hw/rtl/gif_lzw_decoder_core.sv */
// gif lzw decoder top level: config registers, front queue, back engine
// depends on gld_pkg, gld_front, gld_back
//
// usage: items (cmd, data_byte) enter on in_valid/in_stall; each item gives
// exactly one result (status, pixel, string_last, pixel_number) on
// out_valid/out_stall. configuration writes use cfg_valid/cfg_ready with
// cfg_index and cfg_data; the user must write only while idle (not enforced).
// a push, start or non-pixel fetch goes straight to its result; a fetch that
// pops the stack reads the stack memory, then gives the pixel; a fetch that
// expands a code first walks the prefix table, one table read and one stack
// memory write per string symbol walked, and then pops the first pixel.
// items are handled one at a time by the back engine; a two-entry queue lets
// the front keep accepting while the engine works.
// reset: registers go to min code size 8, expected pixels 0, the decoder is
// cleared as after a start. table and stack memories are not cleared.
// a stalled result holds; the engine waits until it is taken.
module gif_lzw_decoder_core import gld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  pixel,
	output logic        string_last,
	output logic [31:0] pixel_number,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	logic [3:0]  min_code_size_q;
	logic [31:0] expected_pixels_q;
	logic        q_valid, q_take;
	item_t       q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_size_q <= 4'd8;
			expected_pixels_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MIN_CODE_SIZE) min_code_size_q <= cfg_data[3:0];
			else expected_pixels_q <= cfg_data;
		end
	end

	gld_front u_front (
		.clk, .arst_n, .in_valid, .in_cmd(cmd), .in_byte(data_byte), .in_stall,
		.q_valid, .q_item, .q_take
	);

	gld_back u_back (
		.clk, .arst_n, .q_valid, .q_item, .q_take,
		.min_code_size(min_code_size_q), .expected_pixels(expected_pixels_q),
		.out_valid, .out_stall, .status, .pixel, .string_last, .pixel_number
	);

	a_pix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_PIXEL |-> pixel == 8'd0 && !string_last)
		else $error("non-pixel result carries pixel data");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("engine took from empty queue");
endmodule
